/* rtl/tangent_space_light_encode_core_defines.svh */
// ----------------------------------------------------------------------------
// Tangent space light encode - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TANGENT_SPACE_LIGHT_ENCODE_CORE_DEFINES_SVH
`define TANGENT_SPACE_LIGHT_ENCODE_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define TSLE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsle port check failed");

// next-cycle implication, masked during reset
`define TSLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsle port check failed");

// next-cycle implication, live through reset
`define TSLE_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tsle reset check failed");

`endif

/* rtl/tsle_pkg.sv */
// ----------------------------------------------------------------------------
// Tangent space light encode - package
// Word types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package tsle_pkg;

   localparam int POS_W      = 32;
   localparam int VEC_W      = 48;
   localparam int COMP_W     = 16;
   localparam int DIFF_W     = 33;
   localparam int UNIT_W     = 32;
   localparam int PROD_W     = 49;
   localparam int SUM_W      = 52;
   localparam int SCALE_W    = 69;
   localparam int SHIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // normalize(3) + squares(1) + sum(1) + root(32) + divide(31) + sign(1)
   localparam int UNIT_LAT   = 69;

   localparam int DIFF_SCALE = 127;
   localparam int DIFF_SHIFT = 44;
   localparam int SPEC_SHIFT = 54;

   localparam logic [SHIN_W-1:0] SHIN_RESET = 16'd256;
   localparam logic [7:0]        GREY_BYTE  = 8'h80;

   localparam logic [1:0] FACING_LIT    = 2'd0;
   localparam logic [1:0] FACING_LIGHT  = 2'd1;
   localparam logic [1:0] FACING_VIEWER = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X   = 3'd0,
      CSR_LIGHT_Y   = 3'd1,
      CSR_LIGHT_Z   = 3'd2,
      CSR_VIEWER_X  = 3'd3,
      CSR_VIEWER_Y  = 3'd4,
      CSR_VIEWER_Z  = 3'd5,
      CSR_SHININESS = 3'd6
   } csr_index_type;

   typedef logic [2:0][DIFF_W-1:0] diff_vec_type;
   typedef logic [2:0][UNIT_W-1:0] unit_vec_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [VEC_W-1:0]        normal_vec;
      logic [VEC_W-1:0]        tangent_vec;
      logic [VEC_W-1:0]        binormal_vec;
      logic                    last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] diffuse_r;
      logic [7:0] diffuse_g;
      logic [7:0] diffuse_b;
      logic [7:0] spec_r;
      logic [7:0] spec_g;
      logic [7:0] spec_b;
      logic [1:0] facing;
      logic       last_out;
   } rsp_type;

   // frame and tag riding alongside the normalize units
   typedef struct packed {
      logic [VEC_W-1:0] normal_vec;
      logic [VEC_W-1:0] tangent_vec;
      logic [VEC_W-1:0] binormal_vec;
      logic             last_in;
   } side_type;

endpackage

/* rtl/tsle_unit.sv */
// ----------------------------------------------------------------------------
// Tangent space light encode - unit vector pipeline
// Block normalize, sum of squares, bit-per-stage square root and
// bit-per-stage divide; emits a signed Q2.30 unit vector.
// ----------------------------------------------------------------------------
module tsle_unit (
   input  logic                   clock,
   input  logic                   en,
   input  tsle_pkg::diff_vec_type d_in,
   output tsle_pkg::unit_vec_type u_out
);
   import tsle_pkg::*;

   localparam int SQ_N = 32;
   localparam int DV_N = 31;

   // stage a: magnitudes
   logic [2:0][32:0] mag_a_ff, mag_a_in;
   logic [2:0]       neg_a_ff;

   // stage b: shift decision
   logic [2:0][32:0] mag_b_ff;
   logic [2:0]       neg_b_ff;
   logic             rsh_b_ff, rsh_b_in;
   logic             zero_b_ff, zero_b_in;
   logic [4:0]       sh_b_ff, sh_b_in;
   logic [32:0]      mx;
   logic [4:0]       msb;

   // stage c: normalized magnitudes
   logic [2:0][30:0] m_c_ff, m_c_in;
   logic [2:0]       neg_c_ff;
   logic             zero_c_ff;

   // stage d: squares
   logic [2:0][61:0] sq_d_ff, sq_d_in;
   logic [2:0][30:0] m_d_ff;
   logic [2:0]       neg_d_ff;
   logic             zero_d_ff;

   // stage e: sum of squares
   logic [63:0]      s_e_ff, s_e_in;
   logic [2:0][30:0] m_e_ff;
   logic [2:0]       neg_e_ff;
   logic             zero_e_ff;

   // root stages
   logic [63:0]      sr_n_ff [SQ_N];
   logic [63:0]      sr_r_ff [SQ_N];
   logic [63:0]      sr_n_in [SQ_N];
   logic [63:0]      sr_r_in [SQ_N];
   logic [63:0]      sr_n_src [SQ_N];
   logic [63:0]      sr_r_src [SQ_N];
   logic [2:0][30:0] sr_m_ff [SQ_N];
   logic [2:0]       sr_neg_ff [SQ_N];
   logic             sr_zero_ff [SQ_N];

   // divide stages
   logic [2:0][32:0] dv_rem_ff [DV_N];
   logic [2:0][32:0] dv_rem_in [DV_N];
   logic [2:0][30:0] dv_q_ff [DV_N];
   logic [2:0][30:0] dv_q_in [DV_N];
   logic [31:0]      dv_den_ff [DV_N];
   logic [31:0]      dv_den_src [DV_N];
   logic [2:0]       dv_neg_ff [DV_N];
   logic             dv_zero_ff [DV_N];

   logic [2:0][31:0] u_ff, u_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_a_in[c] = d_in[c][32] ? (~d_in[c] + 33'd1) : d_in[c];
      end
   end

   always_comb begin
      mx = mag_a_ff[0];
      if (mag_a_ff[1] > mx) mx = mag_a_ff[1];
      if (mag_a_ff[2] > mx) mx = mag_a_ff[2];
      msb = '0;
      for (int i = 0; i < 31; i++) begin
         if (mx[i]) msb = 5'(i);
      end
      rsh_b_in  = mx[32] | mx[31];
      zero_b_in = (mx == '0);
      sh_b_in   = 5'd30 - msb;
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         m_c_in[c]  = rsh_b_ff ? 31'(mag_b_ff[c] >> 1) : 31'(mag_b_ff[c] << sh_b_ff);
         sq_d_in[c] = 62'(m_c_ff[c]) * 62'(m_c_ff[c]);
      end
      s_e_in = 64'(sq_d_ff[0]) + 64'(sq_d_ff[1]) + 64'(sq_d_ff[2]);
   end

   // restoring square root, one result bit per stage
   always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      sr_n_src[0] = s_e_ff;
      sr_r_src[0] = '0;
      for (int k = 1; k < SQ_N; k++) begin
         sr_n_src[k] = sr_n_ff[k-1];
         sr_r_src[k] = sr_r_ff[k-1];
      end
      for (int k = 0; k < SQ_N; k++) begin
         bitv  = 64'd1 << (62 - 2 * k);
         trial = sr_r_src[k] + bitv;
         if (sr_n_src[k] >= trial) begin
            sr_n_in[k] = sr_n_src[k] - trial;
            sr_r_in[k] = (sr_r_src[k] >> 1) + bitv;
         end else begin
            sr_n_in[k] = sr_n_src[k];
            sr_r_in[k] = sr_r_src[k] >> 1;
         end
      end
   end

   // restoring divide of m * 2^30 by the root; m never exceeds the root
   always_comb begin
      logic [32:0] rin;
      logic [30:0] qprev;
      logic        ge;
      dv_den_src[0] = sr_r_ff[SQ_N-1][31:0];
      for (int j = 1; j < DV_N; j++) begin
         dv_den_src[j] = dv_den_ff[j-1];
      end
      for (int j = 0; j < DV_N; j++) begin
         for (int c = 0; c < 3; c++) begin
            if (j == 0) begin
               rin   = {2'b00, sr_m_ff[SQ_N-1][c]};
               qprev = '0;
            end else begin
               rin   = {dv_rem_ff[(j == 0) ? 0 : j-1][c][31:0], 1'b0};
               qprev = dv_q_ff[(j == 0) ? 0 : j-1][c];
            end
            ge = (rin >= {1'b0, dv_den_src[j]});
            dv_rem_in[j][c] = ge ? (rin - {1'b0, dv_den_src[j]}) : rin;
            dv_q_in[j][c]   = {qprev[29:0], ge};
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (dv_zero_ff[DV_N-1]) begin
            u_in[c] = '0;
         end else if (dv_neg_ff[DV_N-1][c]) begin
            u_in[c] = -{1'b0, dv_q_ff[DV_N-1][c]};
         end else begin
            u_in[c] = {1'b0, dv_q_ff[DV_N-1][c]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff <= mag_a_in;
         for (int c = 0; c < 3; c++) neg_a_ff[c] <= d_in[c][32];

         mag_b_ff  <= mag_a_ff;
         neg_b_ff  <= neg_a_ff;
         rsh_b_ff  <= rsh_b_in;
         zero_b_ff <= zero_b_in;
         sh_b_ff   <= sh_b_in;

         m_c_ff    <= m_c_in;
         neg_c_ff  <= neg_b_ff;
         zero_c_ff <= zero_b_ff;

         sq_d_ff   <= sq_d_in;
         m_d_ff    <= m_c_ff;
         neg_d_ff  <= neg_c_ff;
         zero_d_ff <= zero_c_ff;

         s_e_ff    <= s_e_in;
         m_e_ff    <= m_d_ff;
         neg_e_ff  <= neg_d_ff;
         zero_e_ff <= zero_d_ff;

         for (int k = 0; k < SQ_N; k++) begin
            sr_n_ff[k] <= sr_n_in[k];
            sr_r_ff[k] <= sr_r_in[k];
         end
         sr_m_ff[0]    <= m_e_ff;
         sr_neg_ff[0]  <= neg_e_ff;
         sr_zero_ff[0] <= zero_e_ff;
         for (int k = 1; k < SQ_N; k++) begin
            sr_m_ff[k]    <= sr_m_ff[k-1];
            sr_neg_ff[k]  <= sr_neg_ff[k-1];
            sr_zero_ff[k] <= sr_zero_ff[k-1];
         end

         for (int j = 0; j < DV_N; j++) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_q_ff[j]   <= dv_q_in[j];
            dv_den_ff[j] <= dv_den_src[j];
         end
         dv_neg_ff[0]  <= sr_neg_ff[SQ_N-1];
         dv_zero_ff[0] <= sr_zero_ff[SQ_N-1];
         for (int j = 1; j < DV_N; j++) begin
            dv_neg_ff[j]  <= dv_neg_ff[j-1];
            dv_zero_ff[j] <= dv_zero_ff[j-1];
         end

         u_ff <= u_in;
      end
   end

   assign u_out = u_ff;

endmodule

/* rtl/tangent_space_light_encode_core.sv */
// ----------------------------------------------------------------------------
// Tangent space light encode core
// Per-vertex dot3 bump map light and half vectors in tangent space.
// ----------------------------------------------------------------------------
//  port group | dir | word        | handshake
//  req_       | in  | req_type    | req_valid / req_stall
//  rsp_       | out | rsp_type    | rsp_valid / rsp_stall
//  csr_       | in  | 32-bit data | csr_we, csr_index
//
//  One vertex per cycle while req_stall is low; the pipeline depth is set by
//  the 32-stage square root and 31-stage divide in each normalize unit.
//  Reset clears valid bits and the output buffer; the CSRs take their reset
//  values. A two-word output buffer absorbs backpressure: req_stall rises
//  only when both entries hold words and the whole pipeline holds.
// ----------------------------------------------------------------------------
module tangent_space_light_encode_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tsle_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tsle_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [tsle_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsle_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tsle_pkg::*;

   localparam int TOT = 1 + UNIT_LAT + 3;

   logic signed [POS_W-1:0] light_x_ff, light_y_ff, light_z_ff;
   logic signed [POS_W-1:0] viewer_x_ff, viewer_y_ff, viewer_z_ff;
   logic [SHIN_W-1:0]       shin_ff;

   logic en;
   logic [TOT-1:0] vld_ff;

   diff_vec_type dl_ff, dl_in, dv_ff, dv_in;
   unit_vec_type ul, uv;
   side_type     sb_ff [UNIT_LAT+1];
   side_type     sb_in;

   logic signed [PROD_W-1:0] pl_ff [3][3];
   logic signed [PROD_W-1:0] ph_ff [3][3];
   logic signed [PROD_W-1:0] pv_ff [3];
   logic signed [PROD_W-1:0] pl_in [3][3];
   logic signed [PROD_W-1:0] ph_in [3][3];
   logic signed [PROD_W-1:0] pv_in [3];
   logic signed [COMP_W-1:0] fc [3][3];
   logic signed [32:0]       hv [3];
   logic                     last1_ff, last2_ff, last3_ff;

   logic signed [SUM_W-1:0]  sl_ff [3];
   logic signed [SUM_W-1:0]  sh_ff [3];
   logic signed [SUM_W-1:0]  svn_ff;
   logic signed [SUM_W-1:0]  sl_in [3];
   logic signed [SUM_W-1:0]  sh_in [3];
   logic signed [SUM_W-1:0]  svn_in;

   logic signed [SCALE_W-1:0] scl_ff [3];
   logic signed [SCALE_W-1:0] sch_ff [3];
   logic signed [SCALE_W-1:0] scl_in [3];
   logic signed [SCALE_W-1:0] sch_in [3];
   logic [1:0]                facing_ff, facing_in;

   rsp_type    rsp_wr;
   rsp_type    buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   function automatic logic [7:0] bias_byte(input logic signed [SCALE_W-1:0] p,
                                            input int sh);
      logic signed [SCALE_W-1:0] v;
      v = p >>> sh;
      if (v > 126) begin
         return 8'hFF;
      end else if (v < -128) begin
         return 8'h00;
      end
      return 8'(v + 128);
   endfunction

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff  <= '0;
         light_y_ff  <= '0;
         light_z_ff  <= '0;
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
         viewer_z_ff <= '0;
         shin_ff     <= SHIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X:   light_x_ff  <= csr_wdata;
            CSR_LIGHT_Y:   light_y_ff  <= csr_wdata;
            CSR_LIGHT_Z:   light_z_ff  <= csr_wdata;
            CSR_VIEWER_X:  viewer_x_ff <= csr_wdata;
            CSR_VIEWER_Y:  viewer_y_ff <= csr_wdata;
            CSR_VIEWER_Z:  viewer_z_ff <= csr_wdata;
            CSR_SHININESS: shin_ff     <= csr_wdata[SHIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = ~en;

   // 33-bit differences
   always_comb begin
      dl_in[0] = {light_x_ff[31], light_x_ff} - {req_data.pos_x[31], req_data.pos_x};
      dl_in[1] = {light_y_ff[31], light_y_ff} - {req_data.pos_y[31], req_data.pos_y};
      dl_in[2] = {light_z_ff[31], light_z_ff} - {req_data.pos_z[31], req_data.pos_z};
      dv_in[0] = {viewer_x_ff[31], viewer_x_ff} - {req_data.pos_x[31], req_data.pos_x};
      dv_in[1] = {viewer_y_ff[31], viewer_y_ff} - {req_data.pos_y[31], req_data.pos_y};
      dv_in[2] = {viewer_z_ff[31], viewer_z_ff} - {req_data.pos_z[31], req_data.pos_z};
      sb_in.normal_vec   = req_data.normal_vec;
      sb_in.tangent_vec  = req_data.tangent_vec;
      sb_in.binormal_vec = req_data.binormal_vec;
      sb_in.last_in      = req_data.last_in;
   end

   tsle_unit u_light (
      .clock (clock),
      .en    (en),
      .d_in  (dl_ff),
      .u_out (ul)
   );

   tsle_unit u_viewer (
      .clock (clock),
      .en    (en),
      .d_in  (dv_ff),
      .u_out (uv)
   );

   // products against tangent (0), binormal (1), normal (2)
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         fc[0][c] = $signed(sb_ff[UNIT_LAT].tangent_vec[COMP_W*c +: COMP_W]);
         fc[1][c] = $signed(sb_ff[UNIT_LAT].binormal_vec[COMP_W*c +: COMP_W]);
         fc[2][c] = $signed(sb_ff[UNIT_LAT].normal_vec[COMP_W*c +: COMP_W]);
         hv[c]    = $signed({ul[c][31], ul[c]}) + $signed({uv[c][31], uv[c]});
      end
      for (int f = 0; f < 3; f++) begin
         for (int c = 0; c < 3; c++) begin
            pl_in[f][c] = PROD_W'($signed(ul[c]) * fc[f][c]);
            ph_in[f][c] = PROD_W'(hv[c] * fc[f][c]);
         end
      end
      for (int c = 0; c < 3; c++) begin
         pv_in[c] = PROD_W'($signed(uv[c]) * fc[2][c]);
      end
   end

   always_comb begin
      for (int f = 0; f < 3; f++) begin
         sl_in[f] = SUM_W'(pl_ff[f][0]) + SUM_W'(pl_ff[f][1]) + SUM_W'(pl_ff[f][2]);
         sh_in[f] = SUM_W'(ph_ff[f][0]) + SUM_W'(ph_ff[f][1]) + SUM_W'(ph_ff[f][2]);
      end
      svn_in = SUM_W'(pv_ff[0]) + SUM_W'(pv_ff[1]) + SUM_W'(pv_ff[2]);
   end

   always_comb begin
      for (int f = 0; f < 3; f++) begin
         scl_in[f] = SCALE_W'(sl_ff[f]) * $signed(SCALE_W'(DIFF_SCALE));
         sch_in[f] = SCALE_W'(sh_ff[f]) * $signed(SCALE_W'({1'b0, shin_ff}));
      end
      // light test wins over viewer test
      if (sl_ff[2] < 0) begin
         facing_in = FACING_LIGHT;
      end else if (svn_ff < 0) begin
         facing_in = FACING_VIEWER;
      end else begin
         facing_in = FACING_LIT;
      end
   end

   always_comb begin
      rsp_wr.facing   = facing_ff;
      rsp_wr.last_out = last3_ff;
      if (facing_ff != FACING_LIT) begin
         rsp_wr.diffuse_r = GREY_BYTE;
         rsp_wr.diffuse_g = GREY_BYTE;
         rsp_wr.diffuse_b = GREY_BYTE;
         rsp_wr.spec_r    = GREY_BYTE;
         rsp_wr.spec_g    = GREY_BYTE;
         rsp_wr.spec_b    = GREY_BYTE;
      end else begin
         rsp_wr.diffuse_r = bias_byte(scl_ff[0], DIFF_SHIFT);
         rsp_wr.diffuse_g = bias_byte(scl_ff[1], DIFF_SHIFT);
         rsp_wr.diffuse_b = bias_byte(scl_ff[2], DIFF_SHIFT);
         rsp_wr.spec_r    = bias_byte(sch_ff[0], SPEC_SHIFT);
         rsp_wr.spec_g    = bias_byte(sch_ff[1], SPEC_SHIFT);
         rsp_wr.spec_b    = bias_byte(sch_ff[2], SPEC_SHIFT);
      end
   end

   // datapath registers, all held together on a stall
   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff    <= dl_in;
         dv_ff    <= dv_in;
         sb_ff[0] <= sb_in;
         for (int s = 1; s <= UNIT_LAT; s++) sb_ff[s] <= sb_ff[s-1];
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         pv_ff    <= pv_in;
         last1_ff <= sb_ff[UNIT_LAT].last_in;
         sl_ff    <= sl_in;
         sh_ff    <= sh_in;
         svn_ff   <= svn_in;
         last2_ff <= last1_ff;
         scl_ff    <= scl_in;
         sch_ff    <= sch_in;
         facing_ff <= facing_in;
         last3_ff  <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOT-2:0], req_valid};
      end
   end

   // two-word output buffer
   assign push      = en & vld_ff[TOT-1];
   assign pop       = rsp_valid & ~rsp_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ptr_ff] <= rsp_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* rtl/tsle_checker.sv */
// ----------------------------------------------------------------------------
// Tangent space light encode - port checker
// Watches the core's ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "tangent_space_light_encode_core_defines.svh"

module tsle_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tsle_pkg::rsp_type rsp_data
);
   import tsle_pkg::*;

   // a held word stays put
   `TSLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // back-facing words are flat grey
   `TSLE_ASSERT_NOW(a_grey, rsp_valid && rsp_data.facing != FACING_LIT, rsp_data.diffuse_r == GREY_BYTE && rsp_data.diffuse_g == GREY_BYTE && rsp_data.diffuse_b == GREY_BYTE && rsp_data.spec_r == GREY_BYTE && rsp_data.spec_g == GREY_BYTE && rsp_data.spec_b == GREY_BYTE)

   // input only backs up behind a waiting word
   `TSLE_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid)

   // reset empties the buffer and opens the input
   `TSLE_ASSERT_RST(a_reset, reset, !rsp_valid && !req_stall)

endmodule

bind tangent_space_light_encode_core tsle_checker u_tsle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
